// File: sv/assert_macros.svh
// Assertion macros for the RTL; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/deq_pkg.sv
// Shared types and codes of the double-ended queue.
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_LIST       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } res_t;

endpackage

// File: sv/double_ended_queue_top.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// The queue holds up to DEPTH values in a ring buffer kept in one RAM with a
// registered read; a front index and an entry count in registers locate the
// held entries. An item carries a command on s_axis_tuser and a value on
// s_axis_tdata. Push front/back, clear, a refused push (status full) and a
// pop or list of an empty queue each give one result and leave the block
// idle. A pop reads the RAM: on accept the read is issued, then the read data
// moves into the output buffer. A listing gives one result per entry, front
// to back, the last one marked by m_axis_tlast; the single RAM read port sets
// the pace, one entry per cycle while the consumer keeps up. Command codes six
// and seven are taken and ignored. Results pass through a two-entry output
// buffer, so a new item is taken while an earlier result still waits; the
// block stalls only when that buffer is full or a RAM read is still in flight.
// All writes happen while idle and every read is issued after them, so no
// access to the same entry ever overlaps. No memory clearing is needed after
// reset.
`include "assert_macros.svh"

module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // slave side: tdata = value[31:0]; tuser = command[2:0]
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic signed [31:0]          s_axis_tdata,
    input  logic [2:0]                  s_axis_tuser,
    // master side: tdata = data[31:0]; tuser = status[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic signed [31:0]          m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_RAM_OUT
    } state_t;

    // advance a ring index by one, wrapping at DEPTH
    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] a);
        logic [IW-1:0] r;
        r = (a == IW'(DEPTH - 1)) ? '0 : a + IW'(1);
        return r;
    endfunction

    // step a ring index back by one, wrapping at zero
    function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] a);
        logic [IW-1:0] r;
        r = (a == '0) ? IW'(DEPTH - 1) : a - IW'(1);
        return r;
    endfunction

    // ring slot at an offset from a base index
    function automatic logic [IW-1:0] add_idx(input logic [IW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    state_t        state_reg, state_next;
    logic [IW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] ptr_reg, ptr_next;    // slot whose data sits in the RAM read register
    logic [CW-1:0] idx_reg, idx_next;    // result number of that slot
    logic [CW-1:0] n_reg, n_next;        // results of the current read run

    logic          accept;
    deq_pkg::cmd_t cmd;
    logic          is_empty, is_full, run_last;

    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;

    logic          ob_valid, ob_ready;
    deq_pkg::res_t ob_res, out_res;

    assign cmd      = deq_pkg::cmd_t'(s_axis_tuser);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign run_last = ((idx_reg + CW'(1)) == n_reg);

    assign s_axis_tready = (state_reg == S_IDLE) && ob_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        ram_we     = 1'b0;
        ram_waddr  = front_reg;
        ram_re     = 1'b0;
        ram_raddr  = front_reg;
        ob_valid   = 1'b0;
        ob_res     = '{data: '0, status: deq_pkg::ST_OK, last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK:
                        begin
                            ob_valid = 1'b1;
                            if (is_full)
                            begin
                                ob_res.status = deq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (cmd == deq_pkg::CMD_PUSH_FRONT)
                                begin
                                    front_next = dec_idx(front_reg);
                                    ram_waddr  = dec_idx(front_reg);
                                end
                                else
                                begin
                                    ram_waddr = add_idx(front_reg, count_reg);
                                end
                            end
                        end
                        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                ob_valid      = 1'b1;
                                ob_res.status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                count_next = count_reg - CW'(1);
                                idx_next   = '0;
                                n_next     = CW'(1);
                                state_next = S_RAM_OUT;
                                if (cmd == deq_pkg::CMD_POP_FRONT)
                                begin
                                    ram_raddr  = front_reg;
                                    front_next = inc_idx(front_reg);
                                end
                                else
                                begin
                                    ram_raddr = add_idx(front_reg, count_reg - CW'(1));
                                end
                                ptr_next = ram_raddr;
                            end
                        end
                        deq_pkg::CMD_LIST:
                        begin
                            if (is_empty)
                            begin
                                ob_valid      = 1'b1;
                                ob_res.status = deq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // start reading at the front
                                ram_re     = 1'b1;
                                ram_raddr  = front_reg;
                                ptr_next   = front_reg;
                                idx_next   = '0;
                                n_next     = count_reg;
                                state_next = S_RAM_OUT;
                            end
                        end
                        deq_pkg::CMD_CLEAR:
                        begin
                            ob_valid   = 1'b1;
                            front_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            // drop unused command codes
                        end
                    endcase
                end
            end
            S_RAM_OUT:
            begin
                // hand the read data on; fetch the next slot once it is taken
                ob_valid    = 1'b1;
                ob_res.data = ram_rdata;
                ob_res.last = run_last;
                if (ob_ready)
                begin
                    if (run_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = inc_idx(ptr_reg);
                        ptr_next  = inc_idx(ptr_reg);
                        idx_next  = idx_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    deq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ob_valid),
        .in_ready  (ob_ready),
        .in_res    (ob_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.data;
    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last;

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(DEPTH), "entry count beyond depth")
    `ASSERT_NEVER(a_front_bound, clk, rst_n, front_reg > IW'(DEPTH - 1), "front index out of ring")
    `ASSERT_NEVER(a_run_bound, clk, rst_n, (state_reg == S_RAM_OUT) && (idx_reg >= n_reg), "read run overrun")
    `ASSERT_PROP(a_pop_count, clk, rst_n, accept && !is_empty && ((cmd == deq_pkg::CMD_POP_FRONT) || (cmd == deq_pkg::CMD_POP_BACK)) |=> (count_reg == $past(count_reg) - CW'(1)) && (state_reg == S_RAM_OUT), "pop did not remove one entry")

endmodule

// File: sv/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/deq_obuf.sv
// Two-entry output buffer that decouples result production from the consumer.
module deq_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  deq_pkg::res_t in_res,
    output logic          out_valid,
    input  logic          out_ready,
    output deq_pkg::res_t out_res
);

    deq_pkg::res_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = slot_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_res;
        end
    end

endmodule
